>>> rtl/core/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types, constants and helpers for the accumulator machine execute
// block: memory geometry, opcode numbers and the inter-module structs.
// ----------------------------------------------------------------------------
package acpu_pkg;

    // word memory depth, must be a power of two
    localparam int MEM_WORDS   = 2048;
    localparam int ADDR_W      = $clog2(MEM_WORDS);
    localparam int WORD_W      = 32;
    localparam int OPC_W       = 6;
    localparam int LOAD_ADDR_W = 11;
    localparam int PC_W        = 11;

    localparam logic [ADDR_W-1:0] SP_TOP = ADDR_W'(MEM_WORDS - 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EXEC = 1'b1;

    localparam logic [WORD_W-1:0] PORT_INT  = 32'd1;
    localparam logic [WORD_W-1:0] PORT_CHAR = 32'd2;

    localparam logic [OPC_W-1:0] OP_LDI  = 6'd1;   // ac = operand
    localparam logic [OPC_W-1:0] OP_LDD  = 6'd2;   // ac = m[a]
    localparam logic [OPC_W-1:0] OP_LDN  = 6'd3;   // ac = m[m[a]]
    localparam logic [OPC_W-1:0] OP_LDX  = 6'd4;   // ac = m[a+x]
    localparam logic [OPC_W-1:0] OP_LDY  = 6'd5;   // ac = m[a+y]
    localparam logic [OPC_W-1:0] OP_LDSX = 6'd6;   // ac = m[sp+x]
    localparam logic [OPC_W-1:0] OP_ST   = 6'd7;
    localparam logic [OPC_W-1:0] OP_GET  = 6'd8;
    localparam logic [OPC_W-1:0] OP_PUT  = 6'd9;
    localparam logic [OPC_W-1:0] OP_ADDX = 6'd10;
    localparam logic [OPC_W-1:0] OP_ADDY = 6'd11;
    localparam logic [OPC_W-1:0] OP_SUBX = 6'd12;
    localparam logic [OPC_W-1:0] OP_SUBY = 6'd13;
    localparam logic [OPC_W-1:0] OP_CPTX = 6'd14;
    localparam logic [OPC_W-1:0] OP_CPFX = 6'd15;
    localparam logic [OPC_W-1:0] OP_CPTY = 6'd16;
    localparam logic [OPC_W-1:0] OP_CPFY = 6'd17;
    localparam logic [OPC_W-1:0] OP_CPTS = 6'd18;
    localparam logic [OPC_W-1:0] OP_CPFS = 6'd19;
    localparam logic [OPC_W-1:0] OP_JMP  = 6'd20;
    localparam logic [OPC_W-1:0] OP_JEQ  = 6'd21;
    localparam logic [OPC_W-1:0] OP_JNE  = 6'd22;
    localparam logic [OPC_W-1:0] OP_CALL = 6'd23;
    localparam logic [OPC_W-1:0] OP_RET  = 6'd24;
    localparam logic [OPC_W-1:0] OP_INCX = 6'd25;
    localparam logic [OPC_W-1:0] OP_DECX = 6'd26;
    localparam logic [OPC_W-1:0] OP_PUSH = 6'd27;
    localparam logic [OPC_W-1:0] OP_POP  = 6'd28;
    localparam logic [OPC_W-1:0] OP_INT  = 6'd29;
    localparam logic [OPC_W-1:0] OP_IRET = 6'd30;
    localparam logic [OPC_W-1:0] OP_END  = 6'd50;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic can_accept;
        logic fire;
        logic ind_wait;
    } t_exec_status;

    typedef struct packed {
        logic              port_valid;
        logic              port_is_char;
        logic [WORD_W-1:0] port_value;
        logic              halted;
        logic              bad_opcode;
        logic [PC_W-1:0]   program_counter;
    } t_result;

    // address modulo the memory size
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [WORD_W-1:0] a);
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [PC_W-1:0] pc_out(input logic [ADDR_W-1:0] p);
        logic [WORD_W-1:0] wide;
        wide = WORD_W'(p);
        return wide[PC_W-1:0];
    endfunction

endpackage

>>> rtl/core/acpu_mem.sv
// ----------------------------------------------------------------------------
// acpu_mem
// Word memory with one read and one write port, registered read data,
// same-address write bypass and a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module acpu_mem import acpu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_req          i_req,
    output logic [WORD_W-1:0] o_rd_data,
    output logic              o_clearing
);

    logic [WORD_W-1:0] r_mem [MEM_WORDS];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_byp;
    logic [WORD_W-1:0] r_byp_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_we;
    logic [ADDR_W-1:0] w_wa;
    logic [WORD_W-1:0] w_wd;

    always_comb begin
        w_we = r_clearing | i_req.wr_en;
        w_wa = r_clearing ? r_clr_addr : i_req.wr_addr;
        w_wd = r_clearing ? '0 : i_req.wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // read of the word written at the same edge returns the new value
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_byp      <= w_we && (w_wa == i_req.rd_addr);
            r_byp_data <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SP_TOP) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_rd_data  = r_byp ? r_byp_data : r_rd_data;
    assign o_clearing = r_clearing;

endmodule

>>> rtl/core/acpu_exec.sv
// ----------------------------------------------------------------------------
// acpu_exec
// Execute stage: holds one accepted transaction, the machine registers,
// issues memory reads and writes and builds the result.
// ----------------------------------------------------------------------------
module acpu_exec import acpu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_mode,
    input  logic [LOAD_ADDR_W-1:0] i_load_address,
    input  logic [WORD_W-1:0]      i_load_data,
    input  logic [OPC_W-1:0]       i_opcode,
    input  logic [WORD_W-1:0]      i_operand,
    input  logic                   i_out_free,
    input  logic [WORD_W-1:0]      i_rd_data,
    output t_mem_req               o_mem_req,
    output t_exec_status           o_status,
    output t_result                o_result
);

    // machine registers
    logic [ADDR_W-1:0]      r_pc;
    logic [ADDR_W-1:0]      r_sp;
    logic [WORD_W-1:0]      r_ac;
    logic [WORD_W-1:0]      r_x;
    logic [WORD_W-1:0]      r_y;

    // transaction in the stage
    logic                   r_e_valid;
    logic                   r_e_phase;
    logic                   r_e_mode;
    logic [LOAD_ADDR_W-1:0] r_e_laddr;
    logic [WORD_W-1:0]      r_e_ldata;
    logic [OPC_W-1:0]       r_e_opc;
    logic [WORD_W-1:0]      r_e_opd;

    logic [ADDR_W-1:0]      n_pc;
    logic [ADDR_W-1:0]      n_sp;
    logic [WORD_W-1:0]      n_ac;
    logic [WORD_W-1:0]      n_x;
    logic [WORD_W-1:0]      n_y;

    logic                   w_wr_en;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic [WORD_W-1:0]      w_wr_data;
    logic                   w_ind_wait;
    logic                   w_fire;
    logic                   w_can_accept;
    logic [ADDR_W-1:0]      w_f_sp;
    logic [WORD_W-1:0]      w_f_x;
    logic [WORD_W-1:0]      w_f_y;
    logic                   w_need_rd;
    logic [ADDR_W-1:0]      w_rd_addr;
    t_result                w_res;

    assign w_ind_wait   = r_e_valid && (r_e_mode == MODE_EXEC) && (r_e_opc == OP_LDN)
                          && !r_e_phase;
    assign w_fire       = r_e_valid && !w_ind_wait && i_out_free;
    assign w_can_accept = !r_e_valid || w_fire;

    always_comb begin
        n_ac      = r_ac;
        n_x       = r_x;
        n_y       = r_y;
        n_sp      = r_sp;
        n_pc      = r_pc;
        w_wr_en   = 1'b0;
        w_wr_addr = wrap_addr(r_e_opd);
        w_wr_data = r_ac;
        w_res     = '0;
        if (r_e_mode == MODE_LOAD) begin
            w_wr_en   = 1'b1;
            w_wr_addr = wrap_addr(WORD_W'(r_e_laddr));
            w_wr_data = r_e_ldata;
        end else begin
            unique case (r_e_opc)
                OP_LDI: n_ac = r_e_opd;
                OP_LDD, OP_LDN, OP_LDX, OP_LDY, OP_LDSX: n_ac = i_rd_data;
                OP_ST: w_wr_en = 1'b1;
                OP_PUT: begin
                    if (r_e_opd == PORT_INT || r_e_opd == PORT_CHAR) begin
                        w_res.port_valid   = 1'b1;
                        w_res.port_is_char = (r_e_opd == PORT_CHAR);
                        w_res.port_value   = r_ac;
                    end
                end
                OP_ADDX: n_ac = r_ac + r_x;
                OP_ADDY: n_ac = r_ac + r_y;
                OP_SUBX: n_ac = r_ac - r_x;
                OP_SUBY: n_ac = r_ac - r_y;
                OP_CPTX: n_x  = r_ac;
                OP_CPFX: n_ac = r_x;
                OP_CPTY: n_y  = r_ac;
                OP_CPFY: n_ac = r_y;
                OP_CPTS: n_sp = wrap_addr(r_ac);
                OP_CPFS: n_ac = WORD_W'(r_sp);
                OP_JMP:  n_pc = wrap_addr(r_e_opd);
                OP_JEQ: begin
                    if (r_ac == '0) n_pc = wrap_addr(r_e_opd);
                end
                OP_JNE: begin
                    if (r_ac != '0) n_pc = wrap_addr(r_e_opd);
                end
                OP_CALL: begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_sp;
                    w_wr_data = WORD_W'(r_pc);
                    n_sp      = r_sp - 1'b1;
                    n_pc      = wrap_addr(r_e_opd);
                end
                OP_RET: begin
                    n_sp = r_sp + 1'b1;
                    n_pc = wrap_addr(i_rd_data);
                end
                OP_INCX: n_x = r_x + 1'b1;
                OP_DECX: n_x = r_x - 1'b1;
                OP_PUSH: begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_sp;
                    n_sp      = r_sp - 1'b1;
                end
                OP_POP: begin
                    n_sp = r_sp + 1'b1;
                    n_ac = i_rd_data;
                end
                OP_END: w_res.halted = 1'b1;
                default: w_res.bad_opcode = !(r_e_opc inside {OP_GET, OP_INT, OP_IRET});
            endcase
        end
        w_res.program_counter = pc_out(n_pc);
    end

    // register values seen by the next transaction's address
    assign w_f_sp = w_fire ? n_sp : r_sp;
    assign w_f_x  = w_fire ? n_x  : r_x;
    assign w_f_y  = w_fire ? n_y  : r_y;

    always_comb begin
        w_need_rd = 1'b0;
        w_rd_addr = wrap_addr(i_operand);
        unique case (i_opcode)
            OP_LDD, OP_LDN: w_need_rd = 1'b1;
            OP_LDX: begin
                w_need_rd = 1'b1;
                w_rd_addr = wrap_addr(i_operand) + w_f_x[ADDR_W-1:0];
            end
            OP_LDY: begin
                w_need_rd = 1'b1;
                w_rd_addr = wrap_addr(i_operand) + w_f_y[ADDR_W-1:0];
            end
            OP_LDSX: begin
                w_need_rd = 1'b1;
                w_rd_addr = w_f_sp + w_f_x[ADDR_W-1:0];
            end
            OP_RET, OP_POP: begin
                w_need_rd = 1'b1;
                w_rd_addr = w_f_sp + 1'b1;
            end
            default: w_need_rd = 1'b0;
        endcase
        // second read of an indirect load goes through the pointer word
        if (w_ind_wait) begin
            w_rd_addr = wrap_addr(i_rd_data);
        end
    end

    always_comb begin
        o_mem_req.rd_en   = w_ind_wait || (i_accept && (i_mode == MODE_EXEC) && w_need_rd);
        o_mem_req.rd_addr = w_rd_addr;
        o_mem_req.wr_en   = w_fire && w_wr_en;
        o_mem_req.wr_addr = w_wr_addr;
        o_mem_req.wr_data = w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_e_phase <= 1'b0;
            r_pc      <= '0;
            r_sp      <= SP_TOP;
            r_ac      <= '0;
            r_x       <= '0;
            r_y       <= '0;
        end else begin
            if (w_fire) begin
                r_pc      <= n_pc;
                r_sp      <= n_sp;
                r_ac      <= n_ac;
                r_x       <= n_x;
                r_y       <= n_y;
                r_e_phase <= 1'b0;
            end else if (w_ind_wait) begin
                r_e_phase <= 1'b1;
            end
            if (w_can_accept) begin
                r_e_valid <= i_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_e_mode  <= i_mode;
            r_e_laddr <= i_load_address;
            r_e_ldata <= i_load_data;
            r_e_opc   <= i_opcode;
            r_e_opd   <= i_operand;
        end
    end

    assign o_status.can_accept = w_can_accept;
    assign o_status.fire       = w_fire;
    assign o_status.ind_wait   = w_ind_wait;
    assign o_result            = w_res;

endmodule

>>> rtl/core/accumulator_cpu_execute.sv
// output: the result is registered in the output register when the stage fires;
//   an indirect load fires only after its second read of the word memory
// throughput: one transaction per cycle while the output is not stalled; an indirect
//   load holds the stage for its two dependent reads of the word memory
// reset: registers take their reset values, then the memory is zero-filled word by
//   word over all MEM_WORDS (2048) words with the input stalled
// ----------------------------------------------------------------------------
// accumulator_cpu_execute
// Accumulator machine that loads memory words and executes one instruction per
// transaction, reporting port writes, halt, bad opcodes and the program counter.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute import acpu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_mode,
    input  logic [LOAD_ADDR_W-1:0]   i_load_address,
    input  logic signed [WORD_W-1:0] i_load_data,
    input  logic [OPC_W-1:0]         i_opcode,
    input  logic signed [WORD_W-1:0] i_operand,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_port_valid,
    output logic                     o_port_is_char,
    output logic signed [WORD_W-1:0] o_port_value,
    output logic                     o_halted,
    output logic                     o_bad_opcode,
    output logic [PC_W-1:0]          o_program_counter
);

    t_mem_req          w_mem_req;
    t_exec_status      w_status;
    t_result           w_result;
    logic [WORD_W-1:0] w_rd_data;
    logic              w_clearing;
    logic              w_accept;
    logic              w_out_free;

    logic              r_out_valid;
    t_result           r_out;

    assign o_in_stall = w_clearing || !w_status.can_accept;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    acpu_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_mem_req),
        .o_rd_data  (w_rd_data),
        .o_clearing (w_clearing)
    );

    acpu_exec u_exec (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_mode         (i_mode),
        .i_load_address (i_load_address),
        .i_load_data    (i_load_data),
        .i_opcode       (i_opcode),
        .i_operand      (i_operand),
        .i_out_free     (w_out_free),
        .i_rd_data      (w_rd_data),
        .o_mem_req      (w_mem_req),
        .o_status       (w_status),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_status.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_status.fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_port_valid      = r_out.port_valid;
    assign o_port_is_char    = r_out.port_is_char;
    assign o_port_value      = r_out.port_value;
    assign o_halted          = r_out.halted;
    assign o_bad_opcode      = r_out.bad_opcode;
    assign o_program_counter = r_out.program_counter;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_in_stall)
        else $error("transaction accepted during memory clear");

    a_no_read_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_mem_req.rd_en)
        else $error("memory read during clear");

    a_ind_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.ind_wait |-> o_in_stall)
        else $error("input accepted while indirect read pending");

    a_ind_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.ind_wait |=> !w_status.ind_wait)
        else $error("indirect second read did not advance");
`endif

endmodule
